[rtl/core/tkl_pkg.sv]
// shared types, constants and defaults for the trie key lookup core
package tkl_pkg;

    // default sizes handed to the top level parameters
    localparam int unsigned NODE_COUNT_DEF = 4096;
    localparam int unsigned INFO_BITS_DEF  = 16;

    // fixed field widths of the stream items
    localparam int unsigned IDX_W      = 12;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned INFO_IN_W  = 16;
    localparam int unsigned INFO_OUT_W = 16;

    // packed widths on the stream ports, rounded up to whole bytes
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 24;

    // item kinds carried in tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_KEY   = 1'b1;

    // one input item after unpacking
    typedef struct packed {
        logic                  kind;
        logic [IDX_W-1:0]      node_addr;
        logic [CHAR_W-1:0]     node_char;
        logic                  has_child;
        logic [IDX_W-1:0]      child_index;
        logic                  has_sibling;
        logic [IDX_W-1:0]      sibling_index;
        logic                  has_info;
        logic [INFO_IN_W-1:0]  info_value;
        logic [CHAR_W-1:0]     key_char;
        logic                  key_last;
    } t_item;

    // link part of one node table entry, the info value sits above it
    typedef struct packed {
        logic              info_ok;
        logic [IDX_W-1:0]  sib;
        logic              sib_ok;
        logic [IDX_W-1:0]  child;
        logic              child_ok;
        logic [CHAR_W-1:0] label;
    } t_node_hdr;

    localparam int unsigned HDR_W = $bits(t_node_hdr);

    // one lookup result
    typedef struct packed {
        logic [INFO_OUT_W-1:0] info;
        logic                  found;
    } t_result;

    // walker sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_CMP,
        ST_RESULT
    } t_walk_state;

endpackage

[rtl/core/tkl_walker.sv]
// node table memory and the sequencer that walks sibling chains per key character
module tkl_walker #(
    parameter int unsigned NODE_COUNT = tkl_pkg::NODE_COUNT_DEF,
    parameter int unsigned INFO_BITS  = tkl_pkg::INFO_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    input  tkl_pkg::t_item               i_item,
    input  logic [tkl_pkg::IDX_W-1:0]    i_root,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output tkl_pkg::t_result             o_res
);

    localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned NW = tkl_pkg::HDR_W + INFO_BITS;
    localparam int unsigned SW = $clog2(NODE_COUNT + 1);
    localparam logic [SW-1:0] STEP_LIMIT = SW'(NODE_COUNT);

    // node table
    logic [NW-1:0] mem [NODE_COUNT];

    tkl_pkg::t_walk_state r_state, n_state;
    logic [tkl_pkg::IDX_W-1:0]  r_cur, n_cur;
    logic                       r_at_start, n_at_start;
    logic                       r_missed, n_missed;
    logic [tkl_pkg::CHAR_W-1:0] r_char, n_char;
    logic                       r_last, n_last;
    logic [SW-1:0]              r_steps, n_steps;
    tkl_pkg::t_result           r_res, n_res;
    logic [NW-1:0]              r_rd_data;

    logic                       rd_en;
    logic [tkl_pkg::IDX_W-1:0]  rd_idx;
    logic                       wr_en;
    logic [NW-1:0]              wr_data;
    tkl_pkg::t_node_hdr         wr_hdr;
    tkl_pkg::t_node_hdr         hdr;
    logic [INFO_BITS-1:0]       rd_info;

    logic take, is_key;
    logic idle_go_root, idle_go_cmp, idle_miss;
    logic root_hit, match, step_go, cmp_desc, cmp_hit_last, cmp_miss;
    logic [SW-1:0] steps_inc;

    function automatic logic idx_in_range(input logic [tkl_pkg::IDX_W-1:0] idx);
        return 32'(idx) < 32'(NODE_COUNT);
    endfunction

    // read port view
    assign hdr     = tkl_pkg::t_node_hdr'(r_rd_data[tkl_pkg::HDR_W-1:0]);
    assign rd_info = r_rd_data[NW-1:tkl_pkg::HDR_W];

    // decisions at item acceptance
    assign take         = i_item_valid && (r_state == tkl_pkg::ST_IDLE);
    assign is_key       = (i_item.kind == tkl_pkg::KIND_KEY);
    assign idle_go_root = is_key && r_at_start && idx_in_range(i_root);
    assign idle_go_cmp  = is_key && !r_at_start && !r_missed && idx_in_range(r_cur);
    assign idle_miss    = is_key && !idle_go_root && !idle_go_cmp;

    // decisions on returned node data
    assign root_hit     = hdr.child_ok && idx_in_range(hdr.child);
    assign match        = (hdr.label == r_char);
    assign steps_inc    = r_steps + 1'b1;
    assign step_go      = !match && hdr.sib_ok && (steps_inc != STEP_LIMIT)
                          && idx_in_range(hdr.sib);
    assign cmp_desc     = match && !r_last && hdr.child_ok;
    assign cmp_hit_last = match && r_last;
    assign cmp_miss     = !step_go && !cmp_desc && !cmp_hit_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tkl_pkg::ST_IDLE: begin
                if (take) begin
                    if (idle_go_root) begin
                        n_state = tkl_pkg::ST_ROOT;
                    end else if (idle_go_cmp) begin
                        n_state = tkl_pkg::ST_CMP;
                    end else if (idle_miss && i_item.key_last) begin
                        n_state = tkl_pkg::ST_RESULT;
                    end
                end
            end
            tkl_pkg::ST_ROOT: begin
                if (root_hit) begin
                    n_state = tkl_pkg::ST_CMP;
                end else if (r_last) begin
                    n_state = tkl_pkg::ST_RESULT;
                end else begin
                    n_state = tkl_pkg::ST_IDLE;
                end
            end
            tkl_pkg::ST_CMP: begin
                if (step_go) begin
                    n_state = tkl_pkg::ST_CMP;
                end else if (r_last) begin
                    n_state = tkl_pkg::ST_RESULT;
                end else begin
                    n_state = tkl_pkg::ST_IDLE;
                end
            end
            tkl_pkg::ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = tkl_pkg::ST_IDLE;
                end
            end
            default: n_state = tkl_pkg::ST_IDLE;
        endcase
    end

    // memory accesses, walk registers and result
    always_comb begin
        o_item_ready = (r_state == tkl_pkg::ST_IDLE);
        o_res_valid  = (r_state == tkl_pkg::ST_RESULT);
        rd_en        = 1'b0;
        rd_idx       = r_cur;
        wr_en        = 1'b0;
        n_cur        = r_cur;
        n_at_start   = r_at_start;
        n_missed     = r_missed;
        n_char       = r_char;
        n_last       = r_last;
        n_steps      = r_steps;
        n_res        = r_res;
        case (r_state)
            tkl_pkg::ST_IDLE: begin
                if (take && !is_key) begin
                    wr_en = idx_in_range(i_item.node_addr);
                end
                if (take && is_key) begin
                    n_char     = i_item.key_char;
                    n_last     = i_item.key_last;
                    n_steps    = '0;
                    n_at_start = 1'b0;
                    n_missed   = idle_miss;
                    n_res      = '0;
                    rd_en      = idle_go_root || idle_go_cmp;
                    rd_idx     = r_at_start ? i_root : r_cur;
                end
            end
            tkl_pkg::ST_ROOT: begin
                n_cur    = hdr.child;
                n_missed = !root_hit;
                rd_en    = root_hit;
                rd_idx   = hdr.child;
            end
            tkl_pkg::ST_CMP: begin
                rd_idx = hdr.sib;
                if (step_go) begin
                    rd_en   = 1'b1;
                    n_cur   = hdr.sib;
                    n_steps = steps_inc;
                end else if (cmp_desc) begin
                    n_cur = hdr.child;
                end else if (cmp_hit_last) begin
                    n_res.found = hdr.info_ok;
                    n_res.info  = hdr.info_ok ? tkl_pkg::INFO_OUT_W'(rd_info) : '0;
                end
                if (cmp_miss) begin
                    n_missed = 1'b1;
                end
            end
            tkl_pkg::ST_RESULT: begin
                if (i_res_ready) begin
                    n_at_start = 1'b1;
                    n_missed   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // write data for a node item
    always_comb begin
        wr_hdr.info_ok  = i_item.has_info;
        wr_hdr.sib      = i_item.sibling_index;
        wr_hdr.sib_ok   = i_item.has_sibling;
        wr_hdr.child    = i_item.child_index;
        wr_hdr.child_ok = i_item.has_child;
        wr_hdr.label    = i_item.node_char;
        wr_data         = {INFO_BITS'(i_item.info_value), wr_hdr};
    end

    // node table ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_item.node_addr)] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[AW'(rd_idx)];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tkl_pkg::ST_IDLE;
            r_cur      <= '0;
            r_at_start <= 1'b1;
            r_missed   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur      <= n_cur;
            r_at_start <= n_at_start;
            r_missed   <= n_missed;
        end
    end

    // per character payload
    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_last  <= n_last;
        r_steps <= n_steps;
        r_res   <= n_res;
    end

    assign o_res = r_res;

endmodule

[rtl/core/trie_key_lookup_core.sv]
// top level of the trie key lookup core: stream ports, root register, output stage
//
// Looks up keys in a trie held as a node table with first-child and next-sibling links.
// Input stream: tuser[0] selects the item kind. Kind 0 writes one node of the table.
// Kind 1 brings one key character, tlast marks the last character of a key.
// The config channel writes the root node index; write it only while the core is idle.
// Each key character is accepted and then walks its sibling chain, reading one node per
// node visited, the node memory read port being the limit (one read per cycle). The
// first character of a key also reads the root node; the last one passes its result
// into the output register. At most NODE_COUNT nodes of a sibling chain are compared
// per character before the key counts as missed.
// Only the last character gives a result item: found and the info value (0 if absent).
// Reset clears the control state and the root register; the node table holds garbage
// until written. A stalled output holds its item; the core keeps taking input items and
// only waits when a second result is ready before the first has been taken.
module trie_key_lookup_core #(
    parameter int unsigned NODE_COUNT = tkl_pkg::NODE_COUNT_DEF,
    parameter int unsigned INFO_BITS  = tkl_pkg::INFO_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // node_addr, node_char, has_child, child_index, has_sibling, sibling_index,
    // has_info, info_value, key_char, zero pad
    input  logic [tkl_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // kind
    input  logic [0:0]                      i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,
    // result items
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // found, result_info, zero pad
    output logic [tkl_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // root node register
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tkl_pkg::IDX_W-1:0]       i_cfg_data
);

    logic [tkl_pkg::IDX_W-1:0] r_root;
    logic                      r_out_valid;
    tkl_pkg::t_result          r_out;
    tkl_pkg::t_item            item;
    tkl_pkg::t_result          res;
    logic                      res_valid;
    logic                      res_ready;

    // unpack the input item
    always_comb begin
        item.kind          = i_s_axis_tuser[0];
        item.node_addr     = i_s_axis_tdata[11:0];
        item.node_char     = i_s_axis_tdata[19:12];
        item.has_child     = i_s_axis_tdata[20];
        item.child_index   = i_s_axis_tdata[32:21];
        item.has_sibling   = i_s_axis_tdata[33];
        item.sibling_index = i_s_axis_tdata[45:34];
        item.has_info      = i_s_axis_tdata[46];
        item.info_value    = i_s_axis_tdata[62:47];
        item.key_char      = i_s_axis_tdata[70:63];
        item.key_last      = i_s_axis_tlast;
    end

    // root node register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_valid) begin
            r_root <= i_cfg_data;
        end
    end

    tkl_walker #(
        .NODE_COUNT (NODE_COUNT),
        .INFO_BITS  (INFO_BITS)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (o_s_axis_tready),
        .i_item       (item),
        .i_root       (r_root),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register, free when empty or being drained
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = tkl_pkg::M_TDATA_W'(r_out);

endmodule
